@@ hw/rtl/dpcrq_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, codes and defaults of the deduplicating chunk request queue.
package dpcrq_pkg;

    localparam int C_NUM_LEVELS  = 16;
    localparam int C_PENDING_CAP = 64;
    localparam int C_LOADED_CAP  = 256;
    localparam int C_COORD_BITS  = 10;

    typedef logic [1:0] t_cmd;
    typedef logic [2:0] t_status;
    typedef logic [3:0] t_level;
    typedef logic [9:0] t_field;

    localparam t_cmd CMD_REQUEST = 2'd0;
    localparam t_cmd CMD_POP     = 2'd1;
    localparam t_cmd CMD_DONE    = 2'd2;

    localparam t_status ST_QUEUED      = 3'd0;
    localparam t_status ST_LOADED      = 3'd1;
    localparam t_status ST_PENDING     = 3'd2;
    localparam t_status ST_PEND_FULL   = 3'd3;
    localparam t_status ST_POPPED      = 3'd4;
    localparam t_status ST_EMPTY       = 3'd5;
    localparam t_status ST_DONE_REC    = 3'd6;
    localparam t_status ST_LOADED_FULL = 3'd7;

    typedef struct packed {
        logic   push;
        logic   pop;
        t_level level;
    } t_fifo_ctl;

    typedef struct packed {
        logic nonempty;
        logic full;
    } t_fifo_sts;

    // address width, never below one bit
    function automatic int clog2_min1(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

endpackage

@@ hw/rtl/dpcrq_ifs.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for chunk commands and their results.
interface dpcrq_req_if
    import dpcrq_pkg::*;
;
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_level chunk_level;
    t_field chunk_z;
    t_field chunk_y;
    t_field chunk_x;

    modport source (output valid, command, chunk_level, chunk_z, chunk_y, chunk_x,
                    input ready);
    modport sink   (input valid, command, chunk_level, chunk_z, chunk_y, chunk_x,
                    output ready);
endinterface

interface dpcrq_rsp_if
    import dpcrq_pkg::*;
;
    logic    valid;
    logic    ready;
    t_status status;
    t_level  out_level;
    t_field  out_z;
    t_field  out_y;
    t_field  out_x;

    modport source (output valid, status, out_level, out_z, out_y, out_x, input ready);
    modport sink   (input valid, status, out_level, out_z, out_y, out_x, output ready);
endinterface

@@ hw/rtl/dpcrq_key_ram.sv @@
`timescale 1ns / 1ps
// Single write port, single registered read port key memory.
module dpcrq_key_ram
    import dpcrq_pkg::*;
#(
    parameter int DEPTH = C_PENDING_CAP,
    parameter int WIDTH = 4 + 3 * C_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [clog2_min1(DEPTH)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]              i_wdata,
    input  logic [clog2_min1(DEPTH)-1:0]  i_raddr,
    output logic [WIDTH-1:0]              o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dpcrq_fifo_bank.sv @@
`timescale 1ns / 1ps
// Per-level circular FIFOs sharing one coordinate memory, with head and count registers.
module dpcrq_fifo_bank
    import dpcrq_pkg::*;
#(
    parameter int NUM_LEVELS  = C_NUM_LEVELS,
    parameter int PENDING_CAP = C_PENDING_CAP,
    parameter int DATA_W      = 3 * C_COORD_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_fifo_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_wdata,
    output t_fifo_sts         o_sts,
    output logic [DATA_W-1:0] o_rdata
);

    localparam int LVW = clog2_min1(NUM_LEVELS);
    localparam int PW  = clog2_min1(PENDING_CAP);
    localparam int CNW = $clog2(PENDING_CAP + 1);
    localparam int SW  = CNW + 1;

    logic [PW-1:0]     r_head  [NUM_LEVELS];
    logic [CNW-1:0]    r_count [NUM_LEVELS];
    logic [DATA_W-1:0] r_mem   [NUM_LEVELS][PENDING_CAP];
    logic [DATA_W-1:0] r_rdata;

    logic [LVW-1:0] lvl;
    logic [PW-1:0]  head;
    logic [CNW-1:0] count;
    logic [SW-1:0]  tail_sum;
    logic [PW-1:0]  tail;
    logic [PW-1:0]  n_head;

    assign lvl   = i_ctl.level[LVW-1:0];
    assign head  = r_head[lvl];
    assign count = r_count[lvl];

    // head + count stays below twice the depth: one compare and subtract wraps it
    assign tail_sum = SW'(head) + SW'(count);
    assign tail     = (tail_sum >= SW'(PENDING_CAP)) ? PW'(tail_sum - SW'(PENDING_CAP))
                                                     : PW'(tail_sum);
    assign n_head   = (head == PW'(PENDING_CAP - 1)) ? '0 : head + PW'(1);

    assign o_sts.nonempty = (count != '0);
    assign o_sts.full     = (count == CNW'(PENDING_CAP));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            if (i_ctl.push) begin
                r_count[lvl] <= count + CNW'(1);
            end else if (i_ctl.pop) begin
                r_count[lvl] <= count - CNW'(1);
                r_head[lvl]  <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[lvl][tail] <= i_wdata;
        end
        if (i_ctl.pop) begin
            r_rdata <= r_mem[lvl][head];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/dedup_priority_chunk_request_queue.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Role    Payload
// i_req     in   sink    command, chunk_level, chunk_z, chunk_y, chunk_x
// o_rsp     out  source  status, out_level, out_z, out_y, out_x
//
// Request and done: one key comparator walks the loaded key memory (up to its fill count)
// and then the pending key memory, one entry a cycle. Pop checks one level a cycle.
// Synchronous active-low reset clears the valid bits, fill count and FIFO pointers;
// no clearing pass is needed. A result waits in the output register while the next
// item is taken; that item's result is held until the register frees up.
module dedup_priority_chunk_request_queue
    import dpcrq_pkg::*;
#(
    parameter int NUM_LEVELS  = C_NUM_LEVELS,
    parameter int PENDING_CAP = C_PENDING_CAP,
    parameter int LOADED_CAP  = C_LOADED_CAP,
    parameter int COORD_BITS  = C_COORD_BITS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dpcrq_req_if.sink     i_req,
    dpcrq_rsp_if.source   o_rsp
);

    localparam int CW  = COORD_BITS;
    localparam int DW  = 3 * CW;
    localparam int KW  = 4 + DW;
    localparam int PAW = clog2_min1(PENDING_CAP);
    localparam int LAW = clog2_min1(LOADED_CAP);
    localparam int LCW = $clog2(LOADED_CAP + 1);
    localparam int PCW = $clog2(PENDING_CAP + 1);
    localparam int IW  = (LCW > PCW) ? LCW : PCW;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LSCAN = 3'd1;
    localparam logic [2:0] S_PSCAN = 3'd2;
    localparam logic [2:0] S_EXEC  = 3'd3;
    localparam logic [2:0] S_PSRCH = 3'd4;
    localparam logic [2:0] S_PREAD = 3'd5;
    localparam logic [2:0] S_RESP  = 3'd6;

    typedef logic [CW-1:0] t_coord;

    logic [2:0]             r_state;
    t_cmd                   r_cmd;
    t_level                 r_lvl;
    logic [DW-1:0]          r_coord;
    logic [IW-1:0]          r_idx;
    logic                   r_rd_vld;
    logic [IW-1:0]          r_rd_idx;
    logic                   r_loaded;
    logic                   r_found;
    logic                   r_slot_ok;
    logic [PAW-1:0]         r_slot;
    logic [PENDING_CAP-1:0] r_pvalid;
    logic [LCW-1:0]         r_load_used;

    t_status r_res_status;
    t_level  r_res_level;
    t_field  r_res_z, r_res_y, r_res_x;
    logic    r_ovld;
    t_status r_o_status;
    t_level  r_o_level;
    t_field  r_o_z, r_o_y, r_o_x;

    logic [KW-1:0] key;
    logic [KW-1:0] pd_rdata, ld_rdata, cmp_key;
    logic          key_eq;
    logic          pv;
    logic [IW-1:0] scan_lim;
    logic          issue, scan_end;
    logic          out_load;
    t_level        lvl_in;
    t_status       n_status;
    logic          do_push, do_pwrite, do_lwrite;
    t_fifo_ctl     fifo_ctl;
    t_fifo_sts     fifo_sts;
    logic [DW-1:0] fifo_rdata;

    assign key    = {r_lvl, r_coord};
    assign lvl_in = (i_req.chunk_level > t_level'(NUM_LEVELS - 1)) ? t_level'(NUM_LEVELS - 1)
                                                                   : i_req.chunk_level;

    // shared comparator: loaded keys first, then pending keys
    assign cmp_key  = (r_state == S_LSCAN) ? ld_rdata : pd_rdata;
    assign key_eq   = (cmp_key == key);
    assign pv       = r_pvalid[r_rd_idx[PAW-1:0]];
    assign scan_lim = (r_state == S_LSCAN) ? IW'(r_load_used) : IW'(PENDING_CAP);
    assign issue    = (r_idx != scan_lim);
    assign scan_end = !issue && !r_rd_vld;

    // output register takes the result once it is empty or being drained
    assign out_load = (r_state == S_RESP) && (!r_ovld || o_rsp.ready);

    dpcrq_key_ram #(
        .DEPTH (PENDING_CAP),
        .WIDTH (KW)
    ) u_pend_keys (
        .i_clk   (i_clk),
        .i_we    (do_pwrite),
        .i_waddr (r_slot),
        .i_wdata (key),
        .i_raddr (r_idx[PAW-1:0]),
        .o_rdata (pd_rdata)
    );

    dpcrq_key_ram #(
        .DEPTH (LOADED_CAP),
        .WIDTH (KW)
    ) u_load_keys (
        .i_clk   (i_clk),
        .i_we    (do_lwrite),
        .i_waddr (r_load_used[LAW-1:0]),
        .i_wdata (key),
        .i_raddr (r_idx[LAW-1:0]),
        .o_rdata (ld_rdata)
    );

    assign fifo_ctl.push  = do_push;
    assign fifo_ctl.pop   = (r_state == S_PSRCH) && fifo_sts.nonempty;
    assign fifo_ctl.level = r_lvl;

    dpcrq_fifo_bank #(
        .NUM_LEVELS  (NUM_LEVELS),
        .PENDING_CAP (PENDING_CAP),
        .DATA_W      (DW)
    ) u_fifos (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (fifo_ctl),
        .i_wdata (r_coord),
        .o_sts   (fifo_sts),
        .o_rdata (fifo_rdata)
    );

    always_comb begin
        n_status  = ST_EMPTY;
        do_push   = 1'b0;
        do_pwrite = 1'b0;
        do_lwrite = 1'b0;
        if (r_state == S_EXEC) begin
            case (r_cmd)
                CMD_REQUEST: begin
                    if (r_loaded) begin
                        n_status = ST_LOADED;
                    end else if (r_found) begin
                        n_status = ST_PENDING;
                    end else if (!r_slot_ok || fifo_sts.full) begin
                        n_status = ST_PEND_FULL;
                    end else begin
                        n_status  = ST_QUEUED;
                        do_push   = 1'b1;
                        do_pwrite = 1'b1;
                    end
                end
                CMD_DONE: begin
                    if (r_loaded) begin
                        n_status = ST_DONE_REC;
                    end else if (r_load_used == LCW'(LOADED_CAP)) begin
                        n_status = ST_LOADED_FULL;
                    end else begin
                        n_status  = ST_DONE_REC;
                        do_lwrite = 1'b1;
                    end
                end
                default: n_status = ST_EMPTY;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pvalid    <= '0;
            r_load_used <= '0;
            r_ovld      <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd       <= i_req.command;
                        // pop starts its search at the top level
                        r_lvl       <= (i_req.command == CMD_POP) ? t_level'(NUM_LEVELS - 1)
                                                                  : lvl_in;
                        r_coord     <= {t_coord'(i_req.chunk_z), t_coord'(i_req.chunk_y),
                                        t_coord'(i_req.chunk_x)};
                        r_idx       <= '0;
                        r_rd_vld    <= 1'b0;
                        r_loaded    <= 1'b0;
                        r_found     <= 1'b0;
                        r_slot_ok   <= 1'b0;
                        r_res_level <= '0;
                        r_res_z     <= '0;
                        r_res_y     <= '0;
                        r_res_x     <= '0;
                        case (i_req.command)
                            CMD_REQUEST, CMD_DONE: r_state <= S_LSCAN;
                            CMD_POP: r_state <= S_PSRCH;
                            default: begin
                                r_res_status <= ST_EMPTY;
                                r_state      <= S_RESP;
                            end
                        endcase
                    end
                end
                S_LSCAN, S_PSCAN: begin
                    r_rd_vld <= issue;
                    r_rd_idx <= r_idx;
                    if (issue) begin
                        r_idx <= r_idx + IW'(1);
                    end
                    if (r_rd_vld) begin
                        if (r_state == S_LSCAN) begin
                            if (key_eq) begin
                                r_loaded <= 1'b1;
                            end
                        end else if (pv && key_eq) begin
                            r_found <= 1'b1;
                            if (r_cmd == CMD_DONE) begin
                                r_pvalid[r_rd_idx[PAW-1:0]] <= 1'b0;
                            end
                        end else if (!pv && !r_slot_ok) begin
                            // first free pending slot
                            r_slot_ok <= 1'b1;
                            r_slot    <= r_rd_idx[PAW-1:0];
                        end
                    end
                    if (scan_end) begin
                        r_idx   <= '0;
                        r_state <= (r_state == S_LSCAN) ? S_PSCAN : S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res_status <= n_status;
                    if (do_pwrite) begin
                        r_pvalid[r_slot] <= 1'b1;
                    end
                    if (do_lwrite) begin
                        r_load_used <= r_load_used + LCW'(1);
                    end
                    r_state <= S_RESP;
                end
                S_PSRCH: begin
                    if (fifo_sts.nonempty) begin
                        r_state <= S_PREAD;
                    end else if (r_lvl == '0) begin
                        r_res_status <= ST_EMPTY;
                        r_state      <= S_RESP;
                    end else begin
                        r_lvl <= r_lvl - t_level'(1);
                    end
                end
                S_PREAD: begin
                    r_res_status <= ST_POPPED;
                    r_res_level  <= r_lvl;
                    r_res_z      <= t_field'(fifo_rdata[3*CW-1:2*CW]);
                    r_res_y      <= t_field'(fifo_rdata[2*CW-1:CW]);
                    r_res_x      <= t_field'(fifo_rdata[CW-1:0]);
                    r_state      <= S_RESP;
                end
                S_RESP: begin
                    if (out_load) begin
                        r_o_status <= r_res_status;
                        r_o_level  <= r_res_level;
                        r_o_z      <= r_res_z;
                        r_o_y      <= r_res_y;
                        r_o_x      <= r_res_x;
                        r_state    <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_req.ready     = (r_state == S_IDLE);
    assign o_rsp.valid     = r_ovld;
    assign o_rsp.status    = r_o_status;
    assign o_rsp.out_level = r_o_level;
    assign o_rsp.out_z     = r_o_z;
    assign o_rsp.out_y     = r_o_y;
    assign o_rsp.out_x     = r_o_x;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("new item taken while the previous one is in progress");

    a_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_POPPED) |->
        (o_rsp.out_level == '0 && o_rsp.out_z == '0 && o_rsp.out_y == '0 &&
         o_rsp.out_x == '0))
        else $error("non-pop result carries chunk fields");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_ctl.pop |=> (r_state == S_PREAD))
        else $error("FIFO pop not followed by the read-data cycle");

    a_load_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_lwrite |-> (r_load_used < LCW'(LOADED_CAP)))
        else $error("loaded table written past its capacity");

endmodule
